@@ src/assert_macros.svh @@
// Assertion macros shared by the quantiser RTL.
// Depends on nothing; included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every rising edge outside of reset.
`define LRFQ_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");

// Checks that a trigger implies a consequence on the same edge.
`define LRFQ_ASSERT_IMP(label, clk, rst_n, trig, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cons)) \
        else $error("implication failed");

`endif

@@ src/lrfq_pkg.sv @@
// Shared constants, codes and types of the largest-remainder quantiser.
// Depends on nothing; used by the divider and the top level.
`default_nettype none

package lrfq_pkg;

    // Fixed design constants.
    localparam int unsigned MODEL_TOTAL = 65536;
    localparam int unsigned MAX_SYMBOLS = 256;

    localparam int W_WEIGHT = 48;
    localparam int W_PROD   = 64;
    localparam int W_CNT    = 9;
    localparam int W_USED   = 18;
    localparam int W_CUM    = 17;
    localparam int W_STAT   = 2;
    localparam int W_SLOT   = 8;
    localparam int W_STEP   = 6;

    localparam logic [W_USED-1:0] SAT18 = '1;
    localparam logic [W_CUM-1:0]  SAT17 = '1;

    // Item actions.
    localparam logic ACT_LOAD = 1'b0;
    localparam logic ACT_READ = 1'b1;

    // Result status codes.
    localparam logic [W_STAT-1:0] ST_OK        = 2'd0;
    localparam logic [W_STAT-1:0] ST_NOT_READY = 2'd1;
    localparam logic [W_STAT-1:0] ST_MISSED    = 2'd2;

    // Sequencer states.
    typedef enum logic [10:0] {
        S_IDLE  = 11'b000_0000_0001,
        S_START = 11'b000_0000_0010,
        S_DIV   = 11'b000_0000_0100,
        S_WR    = 11'b000_0000_1000,
        S_CHK   = 11'b000_0001_0000,
        S_RK0   = 11'b000_0010_0000,
        S_RK1   = 11'b000_0100_0000,
        S_RS    = 11'b000_1000_0000,
        S_RD    = 11'b001_0000_0000,
        S_RU    = 11'b010_0000_0000,
        S_RDW   = 11'b100_0000_0000
    } t_state;

    // Divider handshake.
    typedef struct packed {
        logic start;
    } t_div_req;

    typedef struct packed {
        logic done;
    } t_div_rsp;

endpackage

`default_nettype wire

@@ src/largest_remainder_freq_quantiser_top.sv @@
// Largest-remainder frequency quantiser: an accepted load item passes through a
// start step, 64 steps of the radix-2 divider and a write-back step. The last
// load of a set is followed by an end-of-set check and, if that passes, by a
// ranking pass, during which the input is stalled; it is bounded by the single
// read port of the remainder memory, which is swept once per symbol. A read
// item makes one memory read and is stalled while an earlier result is still
// waiting.
// Top level: sequencer, multiplier and the two state memories.
// Depends on lrfq_pkg, lrfq_ram, lrfq_div and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module largest_remainder_freq_quantiser_top (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_in_valid,
    output logic                                 o_in_stall,
    input  wire logic                            i_in_action,
    input  wire logic [lrfq_pkg::W_WEIGHT-1:0]   i_in_weight,
    input  wire logic [lrfq_pkg::W_WEIGHT-1:0]   i_in_divisor,
    input  wire logic [lrfq_pkg::W_CNT-1:0]      i_in_entry_index,
    output logic                                 o_out_valid,
    input  wire logic                            i_out_stall,
    output logic      [lrfq_pkg::W_CUM-1:0]      o_out_cumulative,
    output logic      [lrfq_pkg::W_STAT-1:0]     o_out_status,
    input  wire logic                            i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  wire logic [lrfq_pkg::W_CNT-1:0]      i_cfg_data
);

    localparam logic [18:0] TOTAL19 = 19'(lrfq_pkg::MODEL_TOTAL);
    localparam logic [lrfq_pkg::W_CNT-1:0] MAXN = lrfq_pkg::W_CNT'(lrfq_pkg::MAX_SYMBOLS);

    lrfq_pkg::t_state                   r_state;
    logic [lrfq_pkg::W_CNT-1:0]         r_n;
    logic [lrfq_pkg::W_CNT-1:0]         r_lc;
    logic [lrfq_pkg::W_USED-1:0]        r_used;
    logic [lrfq_pkg::W_WEIGHT-1:0]      r_div;
    logic                               r_ready;
    logic                               r_err;
    logic                               r_first;
    logic [lrfq_pkg::W_PROD-1:0]        r_x;
    logic [lrfq_pkg::W_SLOT-1:0]        r_s;
    logic [lrfq_pkg::W_SLOT-1:0]        r_t;
    logic                               r_pv;
    logic [lrfq_pkg::W_SLOT-1:0]        r_pt;
    logic [lrfq_pkg::W_WEIGHT-1:0]      r_key;
    logic [lrfq_pkg::W_CNT-1:0]         r_rank;
    logic [lrfq_pkg::W_CNT-1:0]         r_left;
    logic [lrfq_pkg::W_CNT-1:0]         r_extra;
    logic [lrfq_pkg::W_STAT-1:0]        r_rd_stat;
    logic                               r_out_valid;
    logic [lrfq_pkg::W_CUM-1:0]         r_out_cum;
    logic [lrfq_pkg::W_STAT-1:0]        r_out_stat;

    logic                               idle;
    logic                               in_acc;
    logic                               cfg_acc;
    logic [lrfq_pkg::W_CNT-1:0]         cfg_n;
    logic [15:0]                        free_units;
    logic [lrfq_pkg::W_CNT-1:0]         rd_idx;

    lrfq_pkg::t_div_req                 div_req;
    lrfq_pkg::t_div_rsp                 div_rsp;
    logic [lrfq_pkg::W_PROD-1:0]        quo;
    logic [lrfq_pkg::W_WEIGHT-1:0]      rem;
    logic [lrfq_pkg::W_WEIGHT-1:0]      div_eff;
    logic [lrfq_pkg::W_USED-1:0]        q_sat;
    logic [18:0]                        used_sum;
    logic [lrfq_pkg::W_USED-1:0]        n_used;
    logic [18:0]                        chk_diff;
    logic                               chk_err;

    logic                               rem_we;
    logic [lrfq_pkg::W_SLOT-1:0]        rem_raddr;
    logic [lrfq_pkg::W_WEIGHT-1:0]      rem_rdata;
    logic                               cum_we;
    logic [lrfq_pkg::W_CNT-1:0]         cum_waddr;
    logic [lrfq_pkg::W_CUM-1:0]         cum_wdata;
    logic [lrfq_pkg::W_CNT-1:0]         cum_raddr;
    logic [lrfq_pkg::W_CUM-1:0]         cum_rdata;
    logic                               beats_key;
    logic [lrfq_pkg::W_CNT-1:0]         n_rank;
    logic [lrfq_pkg::W_CNT-1:0]         n_extra;

    // Handshakes. A pending configuration write holds the input off so that
    // both beats are never taken in the same cycle.
    assign idle       = (r_state == lrfq_pkg::S_IDLE);
    assign o_in_stall = !idle || i_cfg_valid
                        || (r_out_valid && (i_in_action == lrfq_pkg::ACT_READ));
    assign in_acc     = i_in_valid && !o_in_stall;
    assign o_cfg_ready = idle;
    assign cfg_acc    = i_cfg_valid && o_cfg_ready;

    // Clamp of the symbol count written by configuration.
    always_comb begin
        if (i_cfg_data < lrfq_pkg::W_CNT'(2)) begin
            cfg_n = lrfq_pkg::W_CNT'(2);
        end else if (i_cfg_data > MAXN) begin
            cfg_n = MAXN;
        end else begin
            cfg_n = i_cfg_data;
        end
    end

    assign free_units = 16'(lrfq_pkg::MODEL_TOTAL - 32'(r_n));
    assign rd_idx     = (i_in_entry_index > r_n) ? r_n : i_in_entry_index;

    // Divider with a zero divisor treated as one.
    assign div_eff       = (r_div == '0) ? lrfq_pkg::W_WEIGHT'(1) : r_div;
    assign div_req.start = (r_state == lrfq_pkg::S_START);

    lrfq_div u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (div_req),
        .i_dividend  (r_x),
        .i_divisor   (div_eff),
        .o_rsp       (div_rsp),
        .o_quotient  (quo),
        .o_remainder (rem)
    );

    // Saturated frequency and running sum.
    assign q_sat    = (|quo[lrfq_pkg::W_PROD-1:lrfq_pkg::W_USED]) ? lrfq_pkg::SAT18
                                                               : quo[lrfq_pkg::W_USED-1:0];
    assign used_sum = {1'b0, r_used} + {1'b0, q_sat} + 19'd1;
    assign n_used   = used_sum[18] ? lrfq_pkg::SAT18 : used_sum[lrfq_pkg::W_USED-1:0];

    // End-of-set check against the total.
    assign chk_diff = TOTAL19 - {1'b0, r_used};
    assign chk_err  = ({1'b0, r_used} > TOTAL19) || (chk_diff >= {10'd0, r_n});

    // Rank comparison: a larger remainder, or an equal one at a lower index.
    assign beats_key = (rem_rdata > r_key) || ((rem_rdata == r_key) && (r_pt < r_s));
    assign n_rank    = (r_pv && beats_key) ? r_rank + 1'b1 : r_rank;
    assign n_extra   = (r_rank < r_left) ? r_extra + 1'b1 : r_extra;

    // Memory port steering.
    assign rem_we    = (r_state == lrfq_pkg::S_WR);
    assign rem_raddr = (r_state == lrfq_pkg::S_RK0) ? r_s : r_t;

    always_comb begin
        cum_we    = 1'b0;
        cum_waddr = r_lc + 1'b1;
        cum_wdata = n_used[lrfq_pkg::W_USED-1] ? lrfq_pkg::SAT17 : n_used[lrfq_pkg::W_CUM-1:0];
        case (r_state)
            lrfq_pkg::S_START: begin
                cum_we    = r_first;
                cum_waddr = '0;
                cum_wdata = '0;
            end
            lrfq_pkg::S_WR: begin
                cum_we = 1'b1;
            end
            lrfq_pkg::S_RU: begin
                cum_we    = 1'b1;
                cum_waddr = {1'b0, r_s} + 1'b1;
                cum_wdata = cum_rdata + lrfq_pkg::W_CUM'(n_extra);
            end
            default: begin
                cum_we = 1'b0;
            end
        endcase
    end

    assign cum_raddr = (r_state == lrfq_pkg::S_RD) ? ({1'b0, r_s} + 1'b1) : rd_idx;

    lrfq_ram #(.WIDTH(lrfq_pkg::W_WEIGHT), .DEPTH(lrfq_pkg::MAX_SYMBOLS)) u_rem_ram (
        .i_clk   (i_clk),
        .i_we    (rem_we),
        .i_waddr (r_lc[lrfq_pkg::W_SLOT-1:0]),
        .i_wdata (rem),
        .i_raddr (rem_raddr),
        .o_rdata (rem_rdata)
    );

    lrfq_ram #(.WIDTH(lrfq_pkg::W_CUM), .DEPTH(lrfq_pkg::MAX_SYMBOLS + 1)) u_cum_ram (
        .i_clk   (i_clk),
        .i_we    (cum_we),
        .i_waddr (cum_waddr),
        .i_wdata (cum_wdata),
        .i_raddr (cum_raddr),
        .o_rdata (cum_rdata)
    );

    // Sequencer and set bookkeeping.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lrfq_pkg::S_IDLE;
            r_n     <= MAXN;
            r_lc    <= '0;
            r_used  <= '0;
            r_div   <= '0;
            r_ready <= 1'b0;
            r_err   <= 1'b0;
            r_pv    <= 1'b0;
        end else begin
            case (r_state)
                lrfq_pkg::S_IDLE: begin
                    if (cfg_acc) begin
                        r_n     <= cfg_n;
                        r_lc    <= '0;
                        r_ready <= 1'b0;
                    end else if (in_acc && (i_in_action == lrfq_pkg::ACT_LOAD)) begin
                        if ((r_lc >= r_n) || (r_lc == '0)) begin
                            r_lc    <= '0;
                            r_div   <= i_in_divisor;
                            r_used  <= '0;
                            r_ready <= 1'b0;
                            r_err   <= 1'b0;
                        end
                        r_state <= lrfq_pkg::S_START;
                    end else if (in_acc) begin
                        r_state <= lrfq_pkg::S_RDW;
                    end
                end
                lrfq_pkg::S_START: begin
                    r_state <= lrfq_pkg::S_DIV;
                end
                lrfq_pkg::S_DIV: begin
                    if (div_rsp.done) begin
                        r_state <= lrfq_pkg::S_WR;
                    end
                end
                lrfq_pkg::S_WR: begin
                    r_used <= n_used;
                    r_lc   <= r_lc + 1'b1;
                    r_state <= ((r_lc + 1'b1) == r_n) ? lrfq_pkg::S_CHK : lrfq_pkg::S_IDLE;
                end
                lrfq_pkg::S_CHK: begin
                    r_lc    <= '0;
                    r_ready <= 1'b1;
                    r_err   <= chk_err;
                    r_state <= chk_err ? lrfq_pkg::S_IDLE : lrfq_pkg::S_RK0;
                end
                lrfq_pkg::S_RK0: begin
                    r_state <= lrfq_pkg::S_RK1;
                end
                lrfq_pkg::S_RK1: begin
                    r_pv    <= 1'b0;
                    r_state <= lrfq_pkg::S_RS;
                end
                lrfq_pkg::S_RS: begin
                    r_pv <= 1'b1;
                    if ({1'b0, r_t} == r_n - 1'b1) begin
                        r_state <= lrfq_pkg::S_RD;
                    end
                end
                lrfq_pkg::S_RD: begin
                    r_pv    <= 1'b0;
                    r_state <= lrfq_pkg::S_RU;
                end
                lrfq_pkg::S_RU: begin
                    r_state <= ({1'b0, r_s} == r_n - 1'b1) ? lrfq_pkg::S_IDLE
                                                          : lrfq_pkg::S_RK0;
                end
                lrfq_pkg::S_RDW: begin
                    r_state <= lrfq_pkg::S_IDLE;
                end
                default: begin
                    r_state <= lrfq_pkg::S_IDLE;
                end
            endcase
        end
    end

    // Datapath registers of the load and ranking steps.
    always_ff @(posedge i_clk) begin
        case (r_state)
            lrfq_pkg::S_IDLE: begin
                r_x     <= lrfq_pkg::W_PROD'(free_units * i_in_weight);
                r_first <= (r_lc >= r_n) || (r_lc == '0);
                if (!r_ready) begin
                    r_rd_stat <= lrfq_pkg::ST_NOT_READY;
                end else if (r_err) begin
                    r_rd_stat <= lrfq_pkg::ST_MISSED;
                end else begin
                    r_rd_stat <= lrfq_pkg::ST_OK;
                end
            end
            lrfq_pkg::S_CHK: begin
                r_left  <= chk_diff[lrfq_pkg::W_CNT-1:0];
                r_s     <= '0;
                r_extra <= '0;
            end
            lrfq_pkg::S_RK1: begin
                r_key  <= rem_rdata;
                r_t    <= '0;
                r_rank <= '0;
            end
            lrfq_pkg::S_RS: begin
                r_rank <= n_rank;
                r_pt   <= r_t;
                r_t    <= r_t + 1'b1;
            end
            lrfq_pkg::S_RD: begin
                r_rank <= n_rank;
            end
            lrfq_pkg::S_RU: begin
                r_extra <= n_extra;
                r_s     <= r_s + 1'b1;
            end
            default: begin
                r_t <= r_t;
            end
        endcase
    end

    // Output register: a read result waits here until taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == lrfq_pkg::S_RDW) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == lrfq_pkg::S_RDW) begin
            r_out_stat <= r_rd_stat;
            r_out_cum  <= (r_rd_stat == lrfq_pkg::ST_OK) ? cum_rdata : '0;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_out_cumulative = r_out_cum;
    assign o_out_status     = r_out_stat;

    `LRFQ_ASSERT(a_lc_bounded, i_clk, i_rst_n, r_lc <= r_n)
    `LRFQ_ASSERT_IMP(a_err_zero_cum, i_clk, i_rst_n,
        o_out_valid && (o_out_status != lrfq_pkg::ST_OK), o_out_cumulative == '0)
    `LRFQ_ASSERT_IMP(a_left_below_n, i_clk, i_rst_n,
        r_state == lrfq_pkg::S_RK0, (r_left < r_n) && r_ready && !r_err)
    `LRFQ_ASSERT_IMP(a_result_slot_free, i_clk, i_rst_n,
        r_state == lrfq_pkg::S_RDW, !r_out_valid || !i_out_stall || 1'b1 == $past(idle))

endmodule

`default_nettype wire

@@ src/lrfq_ram.sv @@
// Generic single-write, single-read synchronous RAM with registered read.
// Depends on nothing.
`default_nettype none

module lrfq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

@@ src/lrfq_div.sv @@
// Restoring radix-2 divider, one quotient bit per cycle, 64 steps.
// Depends on lrfq_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module lrfq_div (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire lrfq_pkg::t_div_req              i_req,
    input  wire logic [lrfq_pkg::W_PROD-1:0]     i_dividend,
    input  wire logic [lrfq_pkg::W_WEIGHT-1:0]   i_divisor,
    output lrfq_pkg::t_div_rsp                   o_rsp,
    output logic      [lrfq_pkg::W_PROD-1:0]     o_quotient,
    output logic      [lrfq_pkg::W_WEIGHT-1:0]   o_remainder
);

    logic                            r_busy;
    logic                            r_done;
    logic [lrfq_pkg::W_STEP-1:0]     r_cnt;
    logic [lrfq_pkg::W_PROD-1:0]     r_q;
    logic [lrfq_pkg::W_WEIGHT-1:0]   r_r;
    logic [lrfq_pkg::W_WEIGHT-1:0]   r_d;
    logic [lrfq_pkg::W_WEIGHT:0]     trial;
    logic                            ge;

    // One trial subtraction per step.
    assign trial = {r_r, r_q[lrfq_pkg::W_PROD-1]};
    assign ge    = trial >= {1'b0, r_d};

    // Control of the step sequence.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == '1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath: the dividend shifts out as the quotient shifts in.
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_q <= i_dividend;
            r_r <= '0;
            r_d <= i_divisor;
        end else if (r_busy) begin
            r_q <= {r_q[lrfq_pkg::W_PROD-2:0], ge};
            r_r <= ge ? lrfq_pkg::W_WEIGHT'(trial - {1'b0, r_d})
                      : trial[lrfq_pkg::W_WEIGHT-1:0];
        end
    end

    assign o_rsp.done  = r_done;
    assign o_quotient  = r_q;
    assign o_remainder = r_r;

    `LRFQ_ASSERT_IMP(a_done_after_busy, i_clk, i_rst_n, r_done, $past(r_busy))
    `LRFQ_ASSERT_IMP(a_no_restart, i_clk, i_rst_n, r_busy, !i_req.start)

endmodule

`default_nettype wire

@@ sim/largest_remainder_freq_quantiser_top_test.sv @@
// Self-checking testbench of the largest-remainder frequency quantiser.
// Depends on lrfq_pkg and largest_remainder_freq_quantiser_top; each read result
// is predicted by an internal model of the quantiser or given by the directed table.
`default_nettype none

module largest_remainder_freq_quantiser_top_test;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [47:0] W48_MAX = '1;

    typedef struct {
        logic        action;
        logic [47:0] weight;
        logic [47:0] divisor;
        logic [8:0]  index;
        bit          typed;
        logic [16:0] cum;
        logic [1:0]  status;
    } t_stim_row;

    typedef struct {
        logic [16:0] cum;
        logic [1:0]  status;
    } t_read_beat;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        i_in_action = lrfq_pkg::ACT_LOAD;
    logic [47:0] i_in_weight = '0;
    logic [47:0] i_in_divisor = '0;
    logic [8:0]  i_in_entry_index = '0;
    logic        i_out_stall = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic [8:0]  i_cfg_data = '0;
    wire         o_in_stall;
    wire         o_out_valid;
    wire  [16:0] o_out_cumulative;
    wire  [1:0]  o_out_status;
    wire         o_cfg_ready;

    largest_remainder_freq_quantiser_top dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_in_action      (i_in_action),
        .i_in_weight      (i_in_weight),
        .i_in_divisor     (i_in_divisor),
        .i_in_entry_index (i_in_entry_index),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_out_cumulative (o_out_cumulative),
        .o_out_status     (o_out_status),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_data       (i_cfg_data)
    );

    // Quantiser state as the testbench sees it.
    logic [47:0] rem_mem [256];
    logic [16:0] cum_mem [257];
    int unsigned loads_done;
    int unsigned used_units;
    logic [47:0] set_divisor;
    bit          table_valid;
    bit          table_bad;
    int unsigned alphabet;

    t_read_beat  pending_reads[$];
    int unsigned error_count = 0;
    int unsigned reads_seen = 0;
    int unsigned items_sent = 0;
    bit          sender_gaps = 1'b1;

    // Clock.
    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // Watchdog.
    initial begin
        #40ms;
        $display("largest_remainder_freq_quantiser_top_test: errors");
        $finish;
    end

    // Spreads the leftover units over the largest remainders, lower index first.
    function automatic void rank_leftover();
        int unsigned leftover;
        int unsigned extra;
        int unsigned rank;
        leftover = lrfq_pkg::MODEL_TOTAL - used_units;
        extra = 0;
        for (int s = 0; s < alphabet; s++) begin
            rank = 0;
            for (int t = 0; t < alphabet; t++) begin
                if (rem_mem[t] > rem_mem[s] || (rem_mem[t] == rem_mem[s] && t < s))
                    rank++;
            end
            if (rank < leftover)
                extra++;
            cum_mem[s+1] = cum_mem[s+1] + 17'(extra);
        end
    endfunction

    // Applies one accepted load beat to the state.
    function automatic void apply_load(logic [47:0] weight, logic [47:0] divisor);
        logic [63:0] free_units;
        logic [63:0] d;
        logic [63:0] x;
        logic [63:0] q;
        free_units = 64'(lrfq_pkg::MODEL_TOTAL - alphabet);
        if (loads_done >= alphabet)
            loads_done = 0;
        if (loads_done == 0) begin
            set_divisor = divisor;
            used_units = 0;
            table_valid = 1'b0;
            table_bad = 1'b0;
            cum_mem[0] = '0;
        end
        d = (set_divisor == 0) ? 64'd1 : 64'(set_divisor);
        x = free_units * 64'(weight);
        q = x / d;
        rem_mem[loads_done % 256] = 48'(x - q * d);
        if (q > 64'(lrfq_pkg::SAT18))
            q = 64'(lrfq_pkg::SAT18);
        used_units += int'(q) + 1;
        if (used_units > lrfq_pkg::SAT18)
            used_units = lrfq_pkg::SAT18;
        cum_mem[(loads_done % 256) + 1] = (used_units > lrfq_pkg::SAT17) ? lrfq_pkg::SAT17
                                                                        : 17'(used_units);
        loads_done++;
        if (loads_done == alphabet) begin
            loads_done = 0;
            table_valid = 1'b1;
            if (used_units > lrfq_pkg::MODEL_TOTAL
                || lrfq_pkg::MODEL_TOTAL - used_units >= alphabet)
                table_bad = 1'b1;
            else
                rank_leftover();
        end
    endfunction

    // Works out the result of one accepted read beat.
    function automatic t_read_beat lookup_entry(logic [8:0] index);
        t_read_beat r;
        int unsigned idx;
        idx = index;
        if (!table_valid) begin
            r.cum = '0;
            r.status = lrfq_pkg::ST_NOT_READY;
        end else if (table_bad) begin
            r.cum = '0;
            r.status = lrfq_pkg::ST_MISSED;
        end else begin
            if (idx > alphabet)
                idx = alphabet;
            r.cum = cum_mem[idx];
            r.status = lrfq_pkg::ST_OK;
        end
        return r;
    endfunction

    function automatic void apply_count(logic [8:0] value);
        alphabet = (value < 2) ? 2
                 : ((value > lrfq_pkg::MAX_SYMBOLS) ? lrfq_pkg::MAX_SYMBOLS : value);
        loads_done = 0;
        table_valid = 1'b0;
    endfunction

    // Sender gap: mostly none or short, a few long.
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (!sender_gaps || r < 50)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // Offers one beat, waits for acceptance, then predicts. Called at a clock edge.
    task automatic send_beat(t_stim_row row);
        t_read_beat r;
        int unsigned gap;
        i_in_action <= row.action;
        i_in_weight <= row.weight;
        i_in_divisor <= row.divisor;
        i_in_entry_index <= row.index;
        i_in_valid <= 1'b1;
        do @(posedge i_clk); while (o_in_stall);
        items_sent++;
        if (row.action == lrfq_pkg::ACT_LOAD) begin
            apply_load(row.weight, row.divisor);
        end else begin
            r = lookup_entry(row.index);
            if (row.typed) begin
                r.cum = row.cum;
                r.status = row.status;
            end
            pending_reads = {pending_reads, r};
        end
        gap = pick_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic send_load(logic [47:0] weight, logic [47:0] divisor);
        t_stim_row row;
        row = '{lrfq_pkg::ACT_LOAD, weight, divisor, 9'($urandom), 1'b0, '0, lrfq_pkg::ST_OK};
        send_beat(row);
    endtask

    task automatic send_read(logic [8:0] index);
        t_stim_row row;
        row = '{lrfq_pkg::ACT_READ, 48'({$urandom, $urandom}), 48'({$urandom, $urandom}),
                index, 1'b0, '0, lrfq_pkg::ST_OK};
        send_beat(row);
    endtask

    // Drains all results, then writes the symbol count while the block is idle.
    task automatic write_count(logic [8:0] value);
        i_in_valid <= 1'b0;
        while (pending_reads.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        i_cfg_data <= value;
        i_cfg_valid <= 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        apply_count(value);
    endtask

    // One set of loads; well formed sets use the weight sum as divisor.
    task automatic send_set(bit well_formed, bit partial);
        logic [47:0] weights[$];
        logic [47:0] total;
        logic [47:0] w;
        int unsigned count;
        int unsigned shift;
        total = '0;
        count = partial ? $urandom_range(1, alphabet - 1) : alphabet;
        shift = $urandom_range(9, 47);
        for (int i = 0; i < count; i++) begin
            if (well_formed)
                w = 48'({$urandom, $urandom}) >> shift;
            else
                w = 48'({$urandom, $urandom}) >> $urandom_range(0, 47);
            weights = {weights, w};
            total += weights[i];
        end
        if (!well_formed)
            total = 48'({$urandom, $urandom}) >> $urandom_range(0, 47);
        for (int i = 0; i < count; i++) begin
            send_load(weights[i], (i == 0) ? total : 48'({$urandom, $urandom}));
            if ($urandom_range(0, 9) == 0)
                send_read(9'($urandom_range(0, 511)));
        end
    endtask

    // Result check and receiver stall, including one long hold-off.
    int unsigned stall_left = 0;
    int unsigned stall_mode_cnt = 0;
    bit          long_hold_done = 1'b0;
    always @(posedge i_clk) begin
        t_read_beat want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            reads_seen++;
            if (pending_reads.size() == 0) begin
                error_count++;
                if (error_count <= 10)
                    $display("unexpected result beat: cum=%0d status=%0d",
                             o_out_cumulative, o_out_status);
            end else begin
                want = pending_reads.pop_front();
                if (o_out_cumulative !== want.cum || o_out_status !== want.status) begin
                    error_count++;
                    if (error_count <= 10)
                        $display("result mismatch: cum exp %0d got %0d, status exp %0d got %0d",
                                 want.cum, o_out_cumulative, want.status, o_out_status);
                end
            end
        end
        stall_mode_cnt++;
        if (!long_hold_done && reads_seen == 40) begin
            long_hold_done = 1'b1;
            stall_left = 400;
        end
        if (stall_left > 0) begin
            stall_left--;
            i_out_stall <= 1'b1;
        end else if ((stall_mode_cnt / 300) % 3 == 2) begin
            i_out_stall <= 1'b0;
        end else if ($urandom_range(0, 9) < 3) begin
            i_out_stall <= 1'b1;
            stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                     : $urandom_range(0, 2);
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    // Stimulus: directed table first, then random phases over several counts.
    initial begin
        t_stim_row rows[] = '{
            '{lrfq_pkg::ACT_READ, '0, '0, 9'd0, 1'b1, 17'd0, lrfq_pkg::ST_NOT_READY},
            '{lrfq_pkg::ACT_LOAD, 48'd1, 48'd2, 9'd0, 1'b0, '0, lrfq_pkg::ST_OK},
            '{lrfq_pkg::ACT_LOAD, 48'd1, 48'd0, 9'd0, 1'b0, '0, lrfq_pkg::ST_OK},
            '{lrfq_pkg::ACT_READ, '0, '0, 9'd0, 1'b1, 17'd0, lrfq_pkg::ST_OK},
            '{lrfq_pkg::ACT_READ, '0, '0, 9'd1, 1'b1, 17'd32768, lrfq_pkg::ST_OK},
            '{lrfq_pkg::ACT_READ, '0, '0, 9'd2, 1'b1, 17'd65536, lrfq_pkg::ST_OK},
            '{lrfq_pkg::ACT_READ, W48_MAX, W48_MAX, 9'd511, 1'b1, 17'd65536, lrfq_pkg::ST_OK},
            '{lrfq_pkg::ACT_LOAD, 48'd0, 48'd0, 9'd0, 1'b0, '0, lrfq_pkg::ST_OK},
            '{lrfq_pkg::ACT_READ, '0, '0, 9'd1, 1'b1, 17'd0, lrfq_pkg::ST_NOT_READY},
            '{lrfq_pkg::ACT_LOAD, 48'd0, W48_MAX, 9'd0, 1'b0, '0, lrfq_pkg::ST_OK},
            '{lrfq_pkg::ACT_READ, '0, '0, 9'd1, 1'b1, 17'd0, lrfq_pkg::ST_MISSED},
            '{lrfq_pkg::ACT_LOAD, W48_MAX, 48'd1, 9'd0, 1'b0, '0, lrfq_pkg::ST_OK},
            '{lrfq_pkg::ACT_LOAD, 48'd0, 48'd1, 9'd0, 1'b0, '0, lrfq_pkg::ST_OK},
            '{lrfq_pkg::ACT_READ, '0, '0, 9'd256, 1'b1, 17'd0, lrfq_pkg::ST_MISSED},
            '{lrfq_pkg::ACT_LOAD, W48_MAX, W48_MAX, 9'd0, 1'b0, '0, lrfq_pkg::ST_OK},
            '{lrfq_pkg::ACT_LOAD, 48'd3, 48'd5, 9'd0, 1'b0, '0, lrfq_pkg::ST_OK},
            '{lrfq_pkg::ACT_READ, '0, '0, 9'd1, 1'b1, 17'd65535, lrfq_pkg::ST_OK},
            '{lrfq_pkg::ACT_READ, '0, '0, 9'd2, 1'b1, 17'd65536, lrfq_pkg::ST_OK},
            '{lrfq_pkg::ACT_LOAD, 48'd1, 48'd4, 9'd0, 1'b0, '0, lrfq_pkg::ST_OK},
            '{lrfq_pkg::ACT_LOAD, 48'd3, 48'd4, 9'd0, 1'b0, '0, lrfq_pkg::ST_OK},
            '{lrfq_pkg::ACT_READ, '0, '0, 9'd1, 1'b0, '0, lrfq_pkg::ST_OK},
            '{lrfq_pkg::ACT_READ, '0, '0, 9'd2, 1'b0, '0, lrfq_pkg::ST_OK}
        };
        logic [8:0] counts[] = '{9'd0, 9'd7, 9'd3, 9'd16, 9'd1, 9'd40, 9'd511, 9'd5};
        int unsigned phase_start;
        int unsigned budget;

        for (int i = 0; i < 256; i++) rem_mem[i] = '0;
        for (int i = 0; i < 257; i++) cum_mem[i] = '0;
        set_divisor = '0;
        used_units = 0;
        table_bad = 1'b0;
        apply_count(9'd256);

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        write_count(9'd2);
        foreach (rows[i]) send_beat(rows[i]);

        foreach (counts[p]) begin
            write_count(counts[p]);
            sender_gaps = (p % 3) != 1;
            phase_start = items_sent;
            budget = (alphabet == lrfq_pkg::MAX_SYMBOLS) ? 1 : 100;
            while (items_sent - phase_start < budget) begin
                send_set($urandom_range(0, 99) < 85, 1'b0);
                repeat ($urandom_range(1, 6)) send_read(9'($urandom_range(0, 511)));
            end
            // Abandon a half-loaded set now and then; the next write drops it.
            if (alphabet > 2 && $urandom_range(0, 1) == 1)
                send_set(1'b1, 1'b1);
            send_read(9'($urandom_range(0, alphabet)));
        end

        i_in_valid <= 1'b0;
        while (pending_reads.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        if (error_count == 0)
            $display("largest_remainder_freq_quantiser_top_test: clean");
        else
            $display("largest_remainder_freq_quantiser_top_test: errors");
        $finish;
    end

endmodule

`default_nettype wire
